// ===== sv/ihrl_pkg.sv =====
// shared types and constants of the intel hex record loader
`default_nettype none
package ihrl_pkg;

    localparam logic [31:0] RESET_PROGRAM_BASE = 32'h1D00_0000;
    localparam logic [31:0] RESET_CONFIG_BASE  = 32'h1FC0_0000;

    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_END     = 8'h01;
    localparam logic [7:0] TYPE_SEGMENT = 8'h02;
    localparam logic [7:0] TYPE_LINEAR  = 8'h04;

    localparam logic [7:0] CHAR_START   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [0:0] {
        CFG_PROGRAM_BASE = 1'b0,
        CFG_CONFIG_BASE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PROGRAM = 2'd0,
        KIND_CONFIG  = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REGION_PROGRAM = 2'd0,
        REGION_CONFIG  = 2'd1,
        REGION_DROP    = 2'd2
    } t_region;

    typedef struct packed {
        logic       is_start;
        logic [7:0] value;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_qport;

endpackage
`default_nettype wire

// ===== sv/ihrl_char_if.sv =====
// character channel of the loader
`default_nettype none
interface ihrl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface
`default_nettype wire

// ===== sv/ihrl_rec_if.sv =====
// write record channel of the loader
`default_nettype none
interface ihrl_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [7:0]  data;

    modport source (output valid, output kind, output offset, output data, input ready);
    modport sink (input valid, input kind, input offset, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ihrl_front.sv =====
// character classifier: pairs hex digits into bytes and marks record starts
`default_nettype none
module ihrl_front import ihrl_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ihrl_char_if.sink     i_char,
    input  wire           i_full,
    output t_qport        o_push
);

    logic       r_pend;
    logic [3:0] r_hi;
    logic       n_pend;
    logic [3:0] n_hi;
    logic       is_digit;
    logic [3:0] digit;
    logic       accept;

    assign i_char.ready = !i_full;
    assign accept       = i_char.valid && !i_full;

    always_comb begin
        is_digit = 1'b1;
        digit    = 4'd0;
        if (i_char.character inside {[8'h30:8'h39]}) begin
            digit = 4'(i_char.character - 8'h30);
        end else if (i_char.character inside {[8'h41:8'h46]}) begin
            digit = 4'(i_char.character - 8'h37);
        end else if (i_char.character inside {[8'h61:8'h66]}) begin
            digit = 4'(i_char.character - 8'h57);
        end else begin
            is_digit = 1'b0;
        end
    end

    always_comb begin
        n_pend       = r_pend;
        n_hi         = r_hi;
        o_push.valid = 1'b0;
        o_push.token = '{is_start: 1'b0, value: {r_hi, digit}};
        if (accept) begin
            if (i_char.character == CHAR_START || i_char.character == CHAR_NEWLINE) begin
                n_pend                = 1'b0;
                o_push.valid          = 1'b1;
                o_push.token.is_start = 1'b1;
            end else if (is_digit) begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                    n_hi   = digit;
                end else begin
                    n_pend       = 1'b0;
                    o_push.valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hi   <= 4'd0;
        end else begin
            r_pend <= n_pend;
            r_hi   <= n_hi;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ihrl_queue.sv =====
// short token queue between classifier and record engine
`default_nettype none
module ihrl_queue import ihrl_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_qport i_push,
    output logic   o_full,
    output t_qport o_head,
    input  wire    i_pop
);

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.token = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push while queue full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/ihrl_back.sv =====
// record engine: header decode, address regions and write generation
`default_nettype none
module ihrl_back import ihrl_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire [31:0]   i_cfg_data,
    input  t_qport       i_head,
    output logic         o_pop,
    ihrl_rec_if.source   o_rec
);

    logic [31:0]      r_program_base;
    logic [31:0]      r_config_base;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_count;
    logic [7:0]       r_addr_hi;
    logic [7:0]       r_type;
    logic [7:0]       r_ext_hi;
    logic [31:0]      r_upper;
    logic [31:0]      r_start;
    logic [31:0]      r_cur_addr;
    t_region          r_region;
    logic             r_finished;
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [31:0]      r_out_offset;
    logic [7:0]       r_out_data;

    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_count;
    logic [7:0]       n_addr_hi;
    logic [7:0]       n_type;
    logic [7:0]       n_ext_hi;
    logic [31:0]      n_upper;
    logic [31:0]      n_start;
    logic [31:0]      n_cur_addr;
    t_region          n_region;
    logic             n_finished;
    logic             n_out_valid;
    t_kind            n_out_kind;
    logic [31:0]      n_out_offset;
    logic [7:0]       n_out_data;

    logic             emit;
    logic [7:0]       b;
    logic [32:0]      diff_conf;
    logic [32:0]      diff_prog;
    logic [POS_W-1:0] k;

    assign o_pop       = i_head.valid && (!r_out_valid || o_rec.ready);
    assign o_rec.valid = r_out_valid;
    assign o_rec.kind  = r_out_kind;
    assign o_rec.offset = r_out_offset;
    assign o_rec.data  = r_out_data;

    assign b         = i_head.token.value;
    assign diff_conf = {1'b0, r_start} - {1'b0, r_config_base};
    assign diff_prog = {1'b0, r_start} - {1'b0, r_program_base};
    assign k         = r_pos - POS_W'(4);

    always_comb begin
        n_pos        = r_pos;
        n_count      = r_count;
        n_addr_hi    = r_addr_hi;
        n_type       = r_type;
        n_ext_hi     = r_ext_hi;
        n_upper      = r_upper;
        n_start      = r_start;
        n_cur_addr   = r_cur_addr;
        n_region     = r_region;
        n_finished   = r_finished;
        emit         = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_offset = r_out_offset;
        n_out_data   = r_out_data;
        if (o_pop && !r_finished) begin
            if (i_head.token.is_start) begin
                n_pos = '0;
            end else begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
                case (r_pos)
                    POS_W'(0): n_count = b;
                    POS_W'(1): n_addr_hi = b;
                    POS_W'(2): n_start = r_upper + {16'd0, r_addr_hi, b};
                    POS_W'(3): begin
                        n_type = b;
                        if (b == TYPE_END) begin
                            n_finished   = 1'b1;
                            emit         = 1'b1;
                            n_out_kind   = KIND_END;
                            n_out_offset = '0;
                            n_out_data   = '0;
                        end else if (b == TYPE_DATA) begin
                            n_cur_addr = r_start;
                            if (!diff_conf[32]) begin
                                n_region  = REGION_CONFIG;
                            end else if (!diff_prog[32]) begin
                                n_region  = REGION_PROGRAM;
                            end else begin
                                n_region  = REGION_DROP;
                            end
                        end
                    end
                    default: begin
                        if (r_type == TYPE_SEGMENT || r_type == TYPE_LINEAR) begin
                            if (r_pos == POS_W'(4)) begin
                                n_ext_hi = b;
                            end else if (r_pos == POS_W'(5)) begin
                                if (r_type == TYPE_LINEAR) begin
                                    n_upper = {r_ext_hi, b, 16'd0};
                                end else begin
                                    n_upper = {12'd0, r_ext_hi, b, 4'd0};
                                end
                            end
                        end else if (r_type == TYPE_DATA && r_region != REGION_DROP) begin
                            n_cur_addr = r_cur_addr + 32'd1;
                            if (k < {1'b0, r_count}) begin
                                emit         = 1'b1;
                                n_out_kind   = (r_region == REGION_CONFIG) ? KIND_CONFIG
                                                                           : KIND_PROGRAM;
                                n_out_offset = r_cur_addr - ((r_region == REGION_CONFIG)
                                                             ? r_config_base
                                                             : r_program_base);
                                n_out_data   = b;
                            end
                        end
                    end
                endcase
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_rec.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_base <= RESET_PROGRAM_BASE;
            r_config_base  <= RESET_CONFIG_BASE;
            r_pos          <= '0;
            r_count        <= '0;
            r_addr_hi      <= '0;
            r_type         <= '0;
            r_ext_hi       <= '0;
            r_upper        <= '0;
            r_start        <= '0;
            r_cur_addr     <= '0;
            r_region       <= REGION_PROGRAM;
            r_finished     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_PROGRAM_BASE) begin
                r_program_base <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_CONFIG_BASE) begin
                r_config_base <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_addr_hi   <= n_addr_hi;
            r_type      <= n_type;
            r_ext_hi    <= n_ext_hi;
            r_upper     <= n_upper;
            r_start     <= n_start;
            r_cur_addr  <= n_cur_addr;
            r_region    <= n_region;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_offset <= n_out_offset;
        r_out_data   <= n_out_data;
    end

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> (r_out_offset == '0 && r_out_data == '0))
        else $error("end marker carries payload");
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !emit)
        else $error("write after end record");
    a_emit_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_pos >= POS_W'(3) && !i_head.token.is_start))
        else $error("write from record header");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || o_rec.ready))
        else $error("output register overwritten");

endmodule
`default_nettype wire

// ===== sv/intel_hex_record_loader_top.sv =====
// top level of the intel hex record loader
//
// i_char carries the hex file text, one ascii character per transaction.
// o_rec carries one transaction per data byte of a type 00 record whose
// start address lies in the program or configuration region (kind 0 or 1,
// offset from the region base, data byte), and one end transaction
// (kind 2, zero offset and data) for the type 01 record.
// the base registers are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// one character is accepted every cycle while the token queue has room; a write
// for the character that completes its data byte is registered in the token
// queue after the classifier and then in the record engine's output register.
// the four entry token queue sets how many characters are taken while o_rec
// is stalled; then i_char.ready falls until the receiver takes a transaction.
// after reset the bases take their default values and all record state is
// cleared; after an end record every character is taken and discarded until
// the next reset.
`default_nettype none
module intel_hex_record_loader_top import ihrl_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire [31:0]   i_cfg_data,
    ihrl_char_if.sink    i_char,
    ihrl_rec_if.source   o_rec
);

    t_qport push;
    t_qport head;
    logic   full;
    logic   pop;

    ihrl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (full),
        .o_push  (push)
    );

    ihrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    ihrl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .o_pop      (pop),
        .o_rec      (o_rec)
    );

endmodule
`default_nettype wire

// ===== verif/ihrl_write_scoreboard_pkg.sv =====
// scoreboard class that predicts and checks the write transactions of the hex loader
`timescale 1ns / 1ps
package ihrl_write_scoreboard_pkg;
    import ihrl_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] offset;
        logic [7:0]  data;
    } t_write;

    class hex_write_scoreboard;
        logic [31:0] program_base;
        logic [31:0] config_base;
        logic [8:0]  byte_pos;
        logic [3:0]  high_nib;
        bit          nib_pending;
        logic [7:0]  rec_count;
        logic [15:0] rec_addr;
        logic [7:0]  rec_type;
        logic [15:0] ext_word;
        logic [31:0] upper_base;
        t_region     rec_region;
        bit          finished;
        t_write      pending_writes[$];
        int          errors;

        function new();
            program_base = RESET_PROGRAM_BASE;
            config_base  = RESET_CONFIG_BASE;
            byte_pos     = '0;
            high_nib     = '0;
            nib_pending  = 1'b0;
            rec_count    = '0;
            rec_addr     = '0;
            rec_type     = '0;
            ext_word     = '0;
            upper_base   = '0;
            rec_region   = REGION_PROGRAM;
            finished     = 1'b0;
            errors       = 0;
        endfunction

        function void set_base(t_cfg_idx idx, logic [31:0] value);
            if (idx == CFG_PROGRAM_BASE) begin
                program_base = value;
            end else begin
                config_base = value;
            end
        endfunction

        static function bit hex_value(logic [7:0] c, output logic [3:0] d);
            d = '0;
            if (c >= "0" && c <= "9") begin
                d = c[3:0];
                return 1'b1;
            end
            if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
                d = c[3:0] + 4'd9;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // true when c would complete an end-of-file type byte
        function bit ends_file(logic [7:0] c);
            logic [3:0] d;
            if (finished || !nib_pending || byte_pos != 9'd3) return 1'b0;
            if (!hex_value(c, d)) return 1'b0;
            return {high_nib, d} == TYPE_END;
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction

        function void note_char(logic [7:0] c);
            logic [3:0]  d;
            logic [7:0]  b;
            logic [8:0]  pos;
            logic [8:0]  k;
            logic [31:0] addr;
            t_write      w;
            if (finished) return;
            if (c == CHAR_START || c == CHAR_NEWLINE) begin
                byte_pos    = '0;
                nib_pending = 1'b0;
                return;
            end
            if (!hex_value(c, d)) return;
            if (!nib_pending) begin
                high_nib    = d;
                nib_pending = 1'b1;
                return;
            end
            nib_pending = 1'b0;
            b = {high_nib, d};
            pos = byte_pos;
            if (byte_pos != POS_MAX) byte_pos = byte_pos + 9'd1;
            case (pos)
                9'd0: rec_count = b;
                9'd1: rec_addr[15:8] = b;
                9'd2: rec_addr[7:0] = b;
                9'd3: begin
                    rec_type = b;
                    if (b == TYPE_END) begin
                        finished = 1'b1;
                        w.kind   = KIND_END;
                        w.offset = '0;
                        w.data   = '0;
                        pending_writes.push_back(w);
                    end else if (b == TYPE_DATA) begin
                        addr = upper_base + {16'h0, rec_addr};
                        if (addr >= config_base) rec_region = REGION_CONFIG;
                        else if (addr >= program_base) rec_region = REGION_PROGRAM;
                        else rec_region = REGION_DROP;
                    end
                end
                default: begin
                    if (rec_type == TYPE_SEGMENT || rec_type == TYPE_LINEAR) begin
                        if (pos == 9'd4) begin
                            ext_word[15:8] = b;
                        end else if (pos == 9'd5) begin
                            ext_word[7:0] = b;
                            if (rec_type == TYPE_LINEAR) upper_base = {ext_word, 16'h0};
                            else upper_base = {12'h0, ext_word, 4'h0};
                        end
                    end else if (rec_type == TYPE_DATA && rec_region != REGION_DROP) begin
                        k = pos - 9'd4;
                        if (k < {1'b0, rec_count}) begin
                            addr = upper_base + {16'h0, rec_addr} + {23'h0, k};
                            if (rec_region == REGION_CONFIG) begin
                                w.kind   = KIND_CONFIG;
                                w.offset = addr - config_base;
                            end else begin
                                w.kind   = KIND_PROGRAM;
                                w.offset = addr - program_base;
                            end
                            w.data = b;
                            pending_writes.push_back(w);
                        end
                    end
                end
            endcase
        endfunction

        function void check_write(logic [1:0] kind, logic [31:0] offset, logic [7:0] data);
            t_write w;
            if (pending_writes.size() == 0) begin
                $error("unexpected transaction: kind %0d offset %h data %h", kind, offset, data);
                errors++;
                return;
            end
            w = pending_writes.pop_front();
            if (kind !== w.kind) begin
                $error("kind mismatch: expected %0d, actual %0d", w.kind, kind);
                errors++;
            end
            if (offset !== w.offset) begin
                $error("offset mismatch: expected %h, actual %h", w.offset, offset);
                errors++;
            end
            if (data !== w.data) begin
                $error("data mismatch: expected %h, actual %h", w.data, data);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_intel_hex_record_loader_top.sv =====
// testbench of the intel hex record loader: random hex text against a predicting scoreboard
`timescale 1ns / 1ps
module tb_intel_hex_record_loader_top;
    import ihrl_pkg::*;
    import ihrl_write_scoreboard_pkg::*;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_CHARS    = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] i_cfg_data;

    ihrl_char_if char_ch ();
    ihrl_rec_if  rec_ch ();

    hex_write_scoreboard sb;
    bit quiet;
    bit squeeze_req;
    bit squeeze_done;
    bit allow_end;
    int sent_chars;
    int cycle_count;

    intel_hex_record_loader_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (char_ch),
        .o_rec      (rec_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) sb.note_char(char_ch.character);
            if (rec_ch.valid && rec_ch.ready) sb.check_write(rec_ch.kind, rec_ch.offset, rec_ch.data);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(20, 60);
    endfunction

    // write receiver with random stalls and one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        rec_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                stall_left = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end else if (stall_left == 0 && !quiet && $urandom_range(5) == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                rec_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rec_ch.ready <= 1'b1;
            end
        end
    end

    task automatic pause_chars(input int n);
        @(negedge i_clk);
        char_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        if (!quiet && $urandom_range(3) == 0) pause_chars(gap_len());
        @(negedge i_clk);
        // the end record is kept for the close of the run
        if (!allow_end && sb.ends_file(c)) c = CHAR_NEWLINE;
        char_ch.valid     <= 1'b1;
        char_ch.character <= c;
        do @(posedge i_clk); while (!char_ch.ready);
        sent_chars++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] ignorable_char();
        logic [7:0] c;
        logic [3:0] d;
        c = 8'($urandom_range(255));
        if (hex_write_scoreboard::hex_value(c, d) || c == CHAR_START || c == CHAR_NEWLINE)
            c = CHAR_CR;
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_char(hex_char(b[7:4]));
        if ($urandom_range(15) == 0) send_char(ignorable_char());
        send_char(hex_char(b[3:0]));
    endtask

    task automatic send_line(input logic [7:0] line[$], input bit newline_start, input bit half);
        int r;
        send_char(newline_start ? CHAR_NEWLINE : CHAR_START);
        foreach (line[i]) send_byte(line[i]);
        if (half) send_char(hex_char(4'($urandom_range(15))));
        r = $urandom_range(9);
        if (r < 6) begin
            send_char(CHAR_CR);
            send_char(CHAR_NEWLINE);
        end else if (r < 8) begin
            send_char(CHAR_NEWLINE);
        end
    endtask

    function automatic logic [15:0] pick_upper();
        logic [31:0] below;
        below = sb.program_base - 32'd1;
        case ($urandom_range(4))
            0: return sb.program_base[31:16];
            1: return sb.config_base[31:16];
            2: return below[31:16];
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_lower();
        case ($urandom_range(3))
            0: return sb.program_base[15:0] + 16'($urandom_range(4)) - 16'd2;
            1: return sb.config_base[15:0] + 16'($urandom_range(4)) - 16'd2;
            2: return 16'hFFF8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic data_record(input logic [15:0] addr, input int count);
        logic [7:0] line[$];
        line = {8'(count), addr[15:8], addr[7:0], TYPE_DATA};
        repeat (count) line.push_back(8'($urandom));
        line.push_back(8'($urandom));
        send_line(line, 1'b0, 1'b0);
    endtask

    task automatic random_record();
        logic [7:0]  line[$];
        logic [7:0]  rtype;
        logic [15:0] word;
        logic [15:0] addr;
        int          count;
        int          ndata;
        int          r;
        bit          half;
        quiet = ($urandom_range(4) == 0);
        half  = ($urandom_range(9) == 0);
        word  = 16'($urandom);
        addr  = 16'($urandom);
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)));
            return;
        end
        if (r < 22) begin
            rtype = TYPE_LINEAR;
            word  = pick_upper();
        end else if (r < 27) begin
            rtype = TYPE_SEGMENT;
        end else if (r < 33) begin
            do rtype = 8'($urandom_range(255));
            while (rtype inside {TYPE_DATA, TYPE_END, TYPE_SEGMENT, TYPE_LINEAR});
        end else begin
            rtype = TYPE_DATA;
            addr  = pick_lower();
        end
        if (rtype == TYPE_LINEAR || rtype == TYPE_SEGMENT) begin
            count = ($urandom_range(5) == 0) ? $urandom_range(255) : 2;
            line = {8'(count), addr[15:8], addr[7:0], rtype, word[15:8], word[7:0]};
        end else begin
            count = ($urandom_range(7) == 0) ? $urandom_range(17, 48) : $urandom_range(16);
            r = $urandom_range(9);
            if (r < 2) ndata = count + $urandom_range(1, 3);
            else if (r < 3) ndata = $urandom_range(count);
            else ndata = count;
            line = {8'(count), addr[15:8], addr[7:0], rtype};
            repeat (ndata) line.push_back(8'($urandom));
        end
        line.push_back(8'($urandom));
        send_line(line, $urandom_range(7) == 0, half);
    endtask

    task automatic run_random(input int n);
        int start;
        start = sent_chars;
        while (sent_chars - start < n) random_record();
        quiet = 1'b0;
    endtask

    task automatic set_bases(input logic [31:0] pb, input logic [31:0] cb);
        @(negedge i_clk);
        char_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        cfg_idx    <= CFG_PROGRAM_BASE;
        i_cfg_data <= pb;
        sb.set_base(CFG_PROGRAM_BASE, pb);
        @(negedge i_clk);
        cfg_idx    <= CFG_CONFIG_BASE;
        i_cfg_data <= cb;
        sb.set_base(CFG_CONFIG_BASE, cb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        send_line({8'h02, 8'h00, 8'h00, TYPE_LINEAR, 8'h1D, 8'h00, 8'hDD}, 1'b0, 1'b0);
        // data beyond the count is dropped
        send_line({8'h02, 8'h00, 8'h00, TYPE_DATA, 8'hFF, 8'h00, 8'hA5, 8'h5A}, 1'b0, 1'b0);
        send_char("G");
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CHAR_CR);
        // zero count, upper word still taken
        send_line({8'h00, 8'h00, 8'h00, TYPE_LINEAR, 8'h1F, 8'hC0}, 1'b0, 1'b0);
        send_line({8'h01, 8'h00, 8'h10, TYPE_DATA, 8'h7E, 8'h00}, 1'b1, 1'b0);
        send_line({8'h02, 8'h00, 8'h00, TYPE_SEGMENT, 8'h10, 8'h00, 8'hEC}, 1'b0, 1'b0);
        send_line({8'h01, 8'hFF, 8'hFF, TYPE_DATA, 8'h11, 8'h00}, 1'b0, 1'b0);
        send_line({8'h04, 8'h12, 8'h34, 8'h03, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0, 1'b1);
        send_line({8'h02, 8'h00, 8'h00, TYPE_LINEAR, 8'h1D, 8'h00, 8'hDD}, 1'b0, 1'b0);
        // receiver holds off while this record fills the block
        squeeze_req = 1'b1;
        data_record(16'h0100, 16);
    endtask

    initial begin
        logic [31:0] pb;
        logic [31:0] cb;
        sb = new();
        quiet        = 1'b0;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;
        allow_end    = 1'b0;
        sent_chars   = 0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        cfg_idx      = CFG_PROGRAM_BASE;
        i_cfg_data   = '0;
        char_ch.valid     = 1'b0;
        char_ch.character = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_CHARS);

        set_bases(32'h0000_0000, 32'hFFFF_FFFF);
        // long line at the widest count
        data_record(16'h0000, 255);
        send_line({8'h00, 8'h00, 8'h00, TYPE_DATA}, 1'b0, 1'b0);
        run_random(PHASE_CHARS);

        set_bases(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(PHASE_CHARS);

        set_bases(32'h0000_0000, 32'h0000_0000);
        run_random(PHASE_CHARS);

        pb = $urandom;
        cb = $urandom;
        if (pb > cb) begin
            pb = pb ^ cb;
            cb = pb ^ cb;
            pb = pb ^ cb;
        end
        set_bases(pb, cb);
        run_random(PHASE_CHARS);

        set_bases($urandom, $urandom);
        run_random(PHASE_CHARS);

        set_bases(RESET_PROGRAM_BASE, RESET_CONFIG_BASE);
        run_random(PHASE_CHARS);

        allow_end = 1'b1;
        send_line({8'h00, 8'h00, 8'h00, TYPE_END, 8'hFF}, 1'b0, 1'b0);
        // everything after the end record is discarded
        send_line({8'h01, 8'h00, 8'h00, TYPE_DATA, 8'h42, 8'h00}, 1'b0, 1'b0);
        repeat (10) send_char(8'($urandom_range(255)));
        set_bases($urandom, $urandom);

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0) $error("%0d expected transactions never arrived", sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
